[src/pcg32_pkg.sv]
// ----------------------------------------------------------------------------
// PCG32 package
// Types and constants shared by the PCG32 generator modules.
// ----------------------------------------------------------------------------
package pcg32_pkg;

	localparam logic [63:0] PCG_MULT   = 64'd6364136223846793005;
	localparam logic [63:0] INC_RESET  = 64'd1442695040888963407;
	localparam logic [63:0] SEED_RESET = 64'd9600629759793949339;

	// Exact quotient by one hundred for any 32-bit word: (w * RECIP100) >> 37.
	localparam logic [31:0] RECIP100   = 32'd1374389535;
	localparam int          RECIP_SHIFT = 37;
	localparam logic [6:0]  HUNDRED    = 7'd100;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_INC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd1;

	localparam logic [1:0] FUNC_WORD    = 2'd0;
	localparam logic [1:0] FUNC_PERCENT = 2'd1;
	localparam logic [1:0] FUNC_BLOCK   = 2'd2;
	localparam logic [1:0] FUNC_RESEED  = 2'd3;

	typedef struct packed {
		logic load_thr;
		logic mul0;
		logic mul1;
		logic mul2;
		logic adv;
		logic div;
		logic rem;
		logic reseed;
		logic push;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

[src/pcg32_datapath.sv]
// ----------------------------------------------------------------------------
// PCG32 datapath
// Generator state, configuration registers, split 64-bit multiply,
// output permutation, percent reduction and the output register.
// ----------------------------------------------------------------------------
module pcg32_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pcg32_pkg::dp_cmd_t             cmd,
	output pcg32_pkg::dp_stat_t            stat,
	input  logic                           cfg_we,
	input  logic [pcg32_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	input  logic [6:0]                     percent_threshold,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    random_word,
	output logic                           decision,
	output logic                           last
);
	import pcg32_pkg::*;

	logic [63:0] state_q;
	logic [63:0] inc_q;
	logic [63:0] seed_q;
	logic [63:0] p0_q;
	logic [31:0] cross_q;
	logic [31:0] word_q;
	logic [6:0]  thr_q;
	logic [26:0] quot_q;
	logic        dec_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic        out_dec_q;
	logic        out_last_q;

	logic [63:0] xs;
	logic [31:0] mixed;
	logic [4:0]  amount;
	logic [63:0] rot2;
	logic [31:0] perm_word;
	logic [63:0] prod0;
	logic [63:0] prod1;
	logic [63:0] prod2;
	logic [63:0] prod_div;
	logic [31:0] hi_sum;
	logic [63:0] inc_odd;
	logic [31:0] q_times_100;
	logic [6:0]  rem7;

	always_comb begin
		xs        = state_q ^ (state_q >> 18);
		mixed     = xs[58:27];
		amount    = state_q[63:59];
		rot2      = {mixed, mixed} >> amount;
		perm_word = rot2[31:0];
		prod0     = state_q[31:0] * PCG_MULT[31:0];
		prod1     = state_q[63:32] * PCG_MULT[31:0];
		prod2     = state_q[31:0] * PCG_MULT[63:32];
		prod_div  = word_q * RECIP100;
		hi_sum    = p0_q[63:32] + cross_q;
		inc_odd   = inc_q | 64'd1;
		q_times_100 = {quot_q[25:0], 6'b0} + {1'b0, quot_q[25:0], 5'b0}
			+ {3'b0, quot_q[26:0], 2'b0};
		rem7      = word_q[6:0] - q_times_100[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEED_RESET;
			inc_q   <= INC_RESET;
			seed_q  <= SEED_RESET;
		end else begin
			if (cfg_we && cfg_index == REG_INC) begin
				inc_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_SEED) begin
				seed_q <= cfg_data;
			end
			if (cmd.reseed) begin
				state_q <= seed_q;
			end else if (cmd.adv) begin
				state_q <= {hi_sum, p0_q[31:0]} + inc_odd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_thr) begin
			thr_q <= percent_threshold;
		end
		if (cmd.mul0) begin
			p0_q   <= prod0;
			word_q <= perm_word;
			dec_q  <= 1'b0;
		end
		if (cmd.mul1) begin
			cross_q <= prod1[31:0];
		end
		if (cmd.mul2) begin
			cross_q <= cross_q + prod2[31:0];
		end
		if (cmd.div) begin
			quot_q <= prod_div[RECIP_SHIFT+26:RECIP_SHIFT];
		end
		if (cmd.rem) begin
			dec_q <= (rem7 < HUNDRED) && (rem7 <= thr_q);
		end
		if (cmd.reseed) begin
			word_q <= 32'd0;
			dec_q  <= 1'b0;
		end
		if (cmd.push) begin
			out_word_q <= word_q;
			out_dec_q  <= dec_q;
			out_last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;
	assign decision    = out_dec_q;
	assign last        = out_last_q;

endmodule

[src/pcg32_controller.sv]
// ----------------------------------------------------------------------------
// PCG32 controller
// Sequences the multiply steps of each draw, the percent reduction,
// block word counting and the transfer of results to the output register.
// ----------------------------------------------------------------------------
module pcg32_controller #(
	parameter int BLOCK_WORDS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  pcg32_pkg::dp_stat_t stat,
	output pcg32_pkg::dp_cmd_t  cmd
);
	import pcg32_pkg::*;

	localparam int CNT_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL0 = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_ADV  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_REM  = 3'd6;
	localparam logic [2:0] ST_PUSH = 3'd7;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [1:0]       func_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             final_word;

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign in_stall   = (state_q != ST_IDLE);
	assign final_word = (func_q != FUNC_BLOCK) || (cnt_q == CNT_W'(BLOCK_WORDS - 1));

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.load_thr = accept;
		cmd.last     = final_word;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_RESEED) begin
						cmd.reseed = 1'b1;
						state_d    = ST_PUSH;
					end else begin
						state_d = ST_MUL0;
					end
				end
			end
			ST_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_ADV;
			end
			ST_ADV: begin
				cmd.adv = 1'b1;
				state_d = (func_q == FUNC_PERCENT) ? ST_DIV : ST_PUSH;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_REM;
			end
			ST_REM: begin
				cmd.rem = 1'b1;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = final_word ? ST_IDLE : ST_MUL0;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			func_q  <= FUNC_WORD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				func_q <= func;
				cnt_q  <= '0;
			end else if (cmd.push && !final_word) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

[src/pcg32_random_generator_top.sv]
// From input transfer to result a word or block word passes the states MUL0, MUL1,
// MUL2, ADV and PUSH, a percent chance adds DIV and REM, a reseed goes straight to PUSH.
// PUSH waits while the output register is stalled. No new request is taken until the
// current one is done; the split 64-bit multiply in three 32-bit steps sets the pace.
// Reset loads the generator state and seed with the seed reset value and the
// stream increment with its reset value; no result is pending after reset.
// ----------------------------------------------------------------------------
// PCG32 random generator top level
// PCG32 XSH RR source with word, percent chance, block and reseed requests.
// ----------------------------------------------------------------------------
module pcg32_random_generator_top #(
	parameter int BLOCK_WORDS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      func,
	input  logic [6:0]                      percent_threshold,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [31:0]                     random_word,
	output logic                            decision,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pcg32_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_data
);
	import pcg32_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	pcg32_controller #(
		.BLOCK_WORDS(BLOCK_WORDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.stat     (stat),
		.cmd      (cmd)
	);

	pcg32_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.percent_threshold (percent_threshold),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.random_word       (random_word),
		.decision          (decision),
		.last              (last)
	);

	// A request keeps the input side closed while it is worked on.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again directly after a transfer");

	// Only a percent chance, which is always the final result, can carry a decision.
	a_decision_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && decision) |-> last)
		else $error("decision set on a result that is not last");

	// While a block is only partly delivered the controller is still busy.
	a_block_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> in_stall)
		else $error("input open in the middle of a block");

endmodule
